// ----- rtl/rue_pkg.sv -----
// Shared constants and types for the radial undistortion block.
package rue_pkg;

    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned COORD_MAX = 127;
    localparam int unsigned OUT_LIM   = COORD_MAX << FRAC_BITS;

    localparam logic [1:0] CFG_CENTER_X     = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y     = 2'd1;
    localparam logic [1:0] CFG_FOCAL_LENGTH = 2'd2;
    localparam logic [1:0] CFG_RADIAL_COEFF = 2'd3;

    localparam logic [15:0] RST_CENTER_X     = 16'd16128;
    localparam logic [15:0] RST_CENTER_Y     = 16'd16128;
    localparam logic [17:0] RST_FOCAL_LENGTH = 18'd51200;
    localparam logic [15:0] RST_RADIAL_COEFF = 16'd0;

    typedef struct packed {
        logic [14:0] x;
        logic [14:0] y;
        logic        in_range;
    } t_result;

endpackage

// ----- rtl/rue_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
module rue_div_pipe #(
    parameter int DW = 18,
    parameter int QW = 24,
    parameter int SW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_bits,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic          r_v    [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_bits [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] bits_in;
        logic [SW-1:0] side_in;
        logic [DW+1:0] diff;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_bits;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_rem;
            assign den_in  = i_den;
            assign bits_in = i_bits;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign bits_in = r_bits[s-1];
            assign side_in = r_side[s-1];
        end

        // trial subtract of the shifted partial remainder
        assign diff   = {1'b0, rem_in, bits_in[QW-1]} - {2'b00, den_in};
        assign n_rem  = diff[DW+1] ? {rem_in[DW-2:0], bits_in[QW-1]} : diff[DW-1:0];
        assign n_bits = {bits_in[QW-2:0], ~diff[DW+1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= den_in;
                r_bits[s] <= n_bits;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_bits[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ----- rtl/rue_skid.sv -----
// Output register with one skid entry that absorbs one word of output stall.
module rue_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rue_pkg::t_result i_word,
    output logic             o_full,
    output logic             o_valid,
    output rue_pkg::t_result o_word,
    input  logic             i_stall
);

    logic             r_out_v;
    logic             r_skid_v;
    rue_pkg::t_result r_out;
    rue_pkg::t_result r_skid;
    logic             take;

    assign take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || take) begin
            r_out_v <= i_valid;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || take) begin
            r_out <= i_word;
        end else if (i_valid) begin
            r_skid <= i_word;
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_word  = r_out;

endmodule

// ----- rtl/radial_undistort_event.sv -----
// Top level: one-coefficient radial lens undistortion of event coordinates.
//
// Takes one event pixel (pix_x, pix_y) per clock while o_stall is low and
// returns the undistorted coordinate in 1/256 pixel with an in-range flag;
// a new word may enter in every cycle in which the input stall is low. The
// pipeline is built around the three pipelined dividers: normalization by
// the focal length (24 stages), the refinement ratio r2/d1 (34 stages) and the
// final division by the refined factor (17 stages), plus 16 stages of
// multiply, add and compare around them. The whole pipeline advances together;
// a single skid entry behind the output register absorbs one word of output
// stall, after which the input stall rises. Configuration registers are read
// in place by their stages, so write them only while the block holds no word.
module radial_undistort_event (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [6:0]  i_pix_x,
    input  logic [6:0]  i_pix_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_undist_x,
    output logic [14:0] o_undist_y,
    output logic        o_in_range,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [17:0] i_cfg_data
);

    localparam logic [23:0] U_SAT  = 24'hFF_FFFF;
    localparam logic [33:0] RC_SAT = 34'h3_FFFF_FFFF;

    typedef struct packed {
        logic        sx;
        logic        sy;
        logic [23:0] mx;
        logic [23:0] my;
        logic        kill;
        logic        neg;
        logic        sat;
    } t_side2;

    typedef struct packed {
        logic kill;
        logic sg;
        logic sat;
    } t_side3;

    // configuration
    logic signed [15:0] r_cx;
    logic signed [15:0] r_cy;
    logic        [17:0] r_f;
    logic signed [15:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= rue_pkg::RST_CENTER_X;
            r_cy <= rue_pkg::RST_CENTER_Y;
            r_f  <= rue_pkg::RST_FOCAL_LENGTH;
            r_k  <= rue_pkg::RST_RADIAL_COEFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rue_pkg::CFG_CENTER_X:     r_cx <= i_cfg_data[15:0];
                rue_pkg::CFG_CENTER_Y:     r_cy <= i_cfg_data[15:0];
                rue_pkg::CFG_FOCAL_LENGTH: r_f  <= i_cfg_data;
                rue_pkg::CFG_RADIAL_COEFF: r_k  <= i_cfg_data[15:0];
            endcase
        end
    end

    // global advance: hold every stage while the skid entry is occupied
    logic en;
    logic skid_full;

    assign en      = !skid_full;
    assign o_stall = skid_full;

    // ---------------- input register ----------------
    logic       r_in_v;
    logic [6:0] r_in_px;
    logic [6:0] r_in_py;

    // ---------------- offset from center ----------------
    logic               r_dx_v;
    logic signed [17:0] r_dx_x;
    logic signed [17:0] r_dx_y;
    logic signed [17:0] n_dx_x;
    logic signed [17:0] n_dx_y;

    assign n_dx_x = $signed({3'b000, r_in_px, 8'h00}) - {{2{r_cx[15]}}, r_cx};
    assign n_dx_y = $signed({3'b000, r_in_py, 8'h00}) - {{2{r_cy[15]}}, r_cy};

    // ---------------- magnitude and saturation of u = dx / f ----------------
    logic        r_nm_v;
    logic [15:0] r_nm_mx;
    logic [15:0] r_nm_my;
    logic        r_nm_sx;
    logic        r_nm_sy;
    logic        r_nm_satx;
    logic        r_nm_saty;
    logic [17:0] neg_dx;
    logic [17:0] neg_dy;
    logic [15:0] n_nm_mx;
    logic [15:0] n_nm_my;

    assign neg_dx  = -r_dx_x;
    assign neg_dy  = -r_dx_y;
    assign n_nm_mx = r_dx_x[17] ? neg_dx[15:0] : r_dx_x[15:0];
    assign n_nm_my = r_dx_y[17] ? neg_dy[15:0] : r_dx_y[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_dx_v <= 1'b0;
            r_nm_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_valid;
            r_dx_v <= r_in_v;
            r_nm_v <= r_dx_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_px   <= i_pix_x;
            r_in_py   <= i_pix_y;
            r_dx_x    <= n_dx_x;
            r_dx_y    <= n_dx_y;
            r_nm_mx   <= n_nm_mx;
            r_nm_my   <= n_nm_my;
            r_nm_sx   <= r_dx_x[17];
            r_nm_sy   <= r_dx_y[17];
            // quotient reaches 2^24 exactly when |dx| >= f * 256
            r_nm_satx <= {10'b0, n_nm_mx} >= {r_f, 8'h00};
            r_nm_saty <= {10'b0, n_nm_my} >= {r_f, 8'h00};
        end
    end

    // ---------------- divider 1: |u| = |dx| * 2^16 / f ----------------
    logic        w_d1x_v;
    logic        w_d1y_v;
    logic [23:0] w_d1x_q;
    logic [23:0] w_d1y_q;
    logic [1:0]  w_d1x_side;
    logic [1:0]  w_d1y_side;

    rue_div_pipe #(.DW(18), .QW(24), .SW(2)) u_div_ux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_nm_v),
        .i_rem   ({10'b0, r_nm_mx[15:8]}),
        .i_den   (r_f),
        .i_bits  ({r_nm_mx[7:0], 16'h0000}),
        .i_side  ({r_nm_sx, r_nm_satx}),
        .o_valid (w_d1x_v),
        .o_quot  (w_d1x_q),
        .o_side  (w_d1x_side)
    );

    rue_div_pipe #(.DW(18), .QW(24), .SW(2)) u_div_uy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_nm_v),
        .i_rem   ({10'b0, r_nm_my[15:8]}),
        .i_den   (r_f),
        .i_bits  ({r_nm_my[7:0], 16'h0000}),
        .i_side  ({r_nm_sy, r_nm_saty}),
        .o_valid (w_d1y_v),
        .o_quot  (w_d1y_q),
        .o_side  (w_d1y_side)
    );

    // ---------------- squares ----------------
    logic        r_sq_v;
    logic [23:0] r_sq_mx;
    logic [23:0] r_sq_my;
    logic        r_sq_sx;
    logic        r_sq_sy;
    logic [47:0] r_sq_x2;
    logic [47:0] r_sq_y2;
    logic [23:0] n_sq_mx;
    logic [23:0] n_sq_my;
    logic [47:0] n_sq_x2;
    logic [47:0] n_sq_y2;

    assign n_sq_mx = w_d1x_side[0] ? U_SAT : w_d1x_q;
    assign n_sq_my = w_d1y_side[0] ? U_SAT : w_d1y_q;
    assign n_sq_x2 = n_sq_mx * n_sq_mx;
    assign n_sq_y2 = n_sq_my * n_sq_my;

    // ---------------- r2 ----------------
    logic        r_r2_v;
    logic [23:0] r_r2_mx;
    logic [23:0] r_r2_my;
    logic        r_r2_sx;
    logic        r_r2_sy;
    logic [32:0] r_r2_r2;
    logic [48:0] n_r2_sum;

    assign n_r2_sum = {1'b0, r_sq_x2} + {1'b0, r_sq_y2};

    // ---------------- k * r2 ----------------
    logic               r_kr_v;
    logic [23:0]        r_kr_mx;
    logic [23:0]        r_kr_my;
    logic               r_kr_sx;
    logic               r_kr_sy;
    logic [32:0]        r_kr_r2;
    logic signed [49:0] r_kr_p;
    logic signed [49:0] n_kr_p;

    assign n_kr_p = r_k * $signed({1'b0, r_r2_r2});

    // ---------------- d1 = 1 + k*r2 ----------------
    logic               r_d1_v;
    logic [23:0]        r_d1_mx;
    logic [23:0]        r_d1_my;
    logic               r_d1_sx;
    logic               r_d1_sy;
    logic [32:0]        r_d1_r2;
    logic signed [35:0] r_d1_d1;
    logic [49:0]        kr_adj;
    logic signed [35:0] n_d1_d1;

    // round the product toward zero before dropping 14 fraction bits
    assign kr_adj  = r_kr_p + (r_kr_p[49] ? 50'h3FFF : 50'h0);
    assign n_d1_d1 = $signed(kr_adj[49:14]) + 36'sd65536;

    // ---------------- |d1| ----------------
    logic        r_a1_v;
    logic [23:0] r_a1_mx;
    logic [23:0] r_a1_my;
    logic        r_a1_sx;
    logic        r_a1_sy;
    logic [32:0] r_a1_r2;
    logic [34:0] r_a1_mag;
    logic        r_a1_neg;
    logic        r_a1_kill;
    logic [35:0] neg_d1;

    assign neg_d1 = -r_d1_d1;

    // ---------------- divider 2 setup ----------------
    logic        r_s1_v;
    logic [32:0] r_s1_r2;
    logic [34:0] r_s1_mag;
    t_side2      r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
            r_r2_v <= 1'b0;
            r_kr_v <= 1'b0;
            r_d1_v <= 1'b0;
            r_a1_v <= 1'b0;
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_sq_v <= w_d1x_v;
            r_r2_v <= r_sq_v;
            r_kr_v <= r_r2_v;
            r_d1_v <= r_kr_v;
            r_a1_v <= r_d1_v;
            r_s1_v <= r_a1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_mx <= n_sq_mx;
            r_sq_my <= n_sq_my;
            r_sq_sx <= w_d1x_side[1];
            r_sq_sy <= w_d1y_side[1];
            r_sq_x2 <= n_sq_x2;
            r_sq_y2 <= n_sq_y2;

            r_r2_mx <= r_sq_mx;
            r_r2_my <= r_sq_my;
            r_r2_sx <= r_sq_sx;
            r_r2_sy <= r_sq_sy;
            r_r2_r2 <= n_r2_sum[48:16];

            r_kr_mx <= r_r2_mx;
            r_kr_my <= r_r2_my;
            r_kr_sx <= r_r2_sx;
            r_kr_sy <= r_r2_sy;
            r_kr_r2 <= r_r2_r2;
            r_kr_p  <= n_kr_p;

            r_d1_mx <= r_kr_mx;
            r_d1_my <= r_kr_my;
            r_d1_sx <= r_kr_sx;
            r_d1_sy <= r_kr_sy;
            r_d1_r2 <= r_kr_r2;
            r_d1_d1 <= n_d1_d1;

            r_a1_mx   <= r_d1_mx;
            r_a1_my   <= r_d1_my;
            r_a1_sx   <= r_d1_sx;
            r_a1_sy   <= r_d1_sy;
            r_a1_r2   <= r_d1_r2;
            r_a1_mag  <= r_d1_d1[35] ? neg_d1[34:0] : r_d1_d1[34:0];
            r_a1_neg  <= r_d1_d1[35];
            r_a1_kill <= (r_d1_d1 == 36'sd0);

            r_s1_r2        <= r_a1_r2;
            r_s1_mag       <= r_a1_mag;
            r_s1_side.sx   <= r_a1_sx;
            r_s1_side.sy   <= r_a1_sy;
            r_s1_side.mx   <= r_a1_mx;
            r_s1_side.my   <= r_a1_my;
            r_s1_side.kill <= r_a1_kill;
            r_s1_side.neg  <= r_a1_neg;
            // ratio reaches 2^34 exactly when r2 >= |d1| * 2^18
            r_s1_side.sat  <= {20'b0, r_a1_r2} >= {r_a1_mag, 18'b0};
        end
    end

    // ---------------- divider 2: |rc| = r2 * 2^16 / |d1| ----------------
    logic        w_d2_v;
    logic [33:0] w_d2_q;
    t_side2      w_d2_side;

    rue_div_pipe #(.DW(35), .QW(34), .SW($bits(t_side2))) u_div_rc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_v),
        .i_rem   ({20'b0, r_s1_r2[32:18]}),
        .i_den   (r_s1_mag),
        .i_bits  ({r_s1_r2[17:0], 16'h0000}),
        .i_side  (r_s1_side),
        .o_valid (w_d2_v),
        .o_quot  (w_d2_q),
        .o_side  (w_d2_side)
    );

    // ---------------- signed rc ----------------
    logic               r_rc_v;
    t_side2             r_rc_side;
    logic signed [35:0] r_rc_rc;
    logic [35:0]        rc_mag;

    assign rc_mag = {2'b00, (w_d2_side.sat ? RC_SAT : w_d2_q)};

    // ---------------- k * rc ----------------
    logic               r_kc_v;
    t_side2             r_kc_side;
    logic signed [51:0] r_kc_p;
    logic signed [51:0] n_kc_p;

    assign n_kc_p = r_k * r_rc_rc;

    // ---------------- d2 = 1 + k*rc ----------------
    logic               r_d2_v;
    t_side2             r_d2_side;
    logic signed [37:0] r_d2_d2;
    logic [51:0]        kc_adj;
    logic signed [37:0] n_d2_d2;

    assign kc_adj  = r_kc_p + (r_kc_p[51] ? 52'h3FFF : 52'h0);
    assign n_d2_d2 = $signed(kc_adj[51:14]) + 38'sd65536;

    // ---------------- |d2| and u * f ----------------
    logic        r_a2_v;
    logic        r_a2_sx;
    logic        r_a2_sy;
    logic        r_a2_kill;
    logic        r_a2_neg;
    logic [35:0] r_a2_mag;
    logic [41:0] r_a2_nx;
    logic [41:0] r_a2_ny;
    logic [37:0] neg_d2;
    logic [41:0] n_a2_nx;
    logic [41:0] n_a2_ny;

    assign neg_d2  = -r_d2_d2;
    assign n_a2_nx = r_d2_side.mx * r_f;
    assign n_a2_ny = r_d2_side.my * r_f;

    // ---------------- divider 3 setup ----------------
    logic        r_s2_v;
    logic [35:0] r_s2_mag;
    logic [41:0] r_s2_nx;
    logic [41:0] r_s2_ny;
    t_side3      r_s2_sx;
    t_side3      r_s2_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_v <= 1'b0;
            r_kc_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_a2_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_rc_v <= w_d2_v;
            r_kc_v <= r_rc_v;
            r_d2_v <= r_kc_v;
            r_a2_v <= r_d2_v;
            r_s2_v <= r_a2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rc_side <= w_d2_side;
            r_rc_rc   <= w_d2_side.neg ? -$signed(rc_mag) : $signed(rc_mag);

            r_kc_side <= r_rc_side;
            r_kc_p    <= n_kc_p;

            r_d2_side <= r_kc_side;
            r_d2_d2   <= n_d2_d2;

            r_a2_sx   <= r_d2_side.sx;
            r_a2_sy   <= r_d2_side.sy;
            r_a2_kill <= r_d2_side.kill || (r_d2_d2 == 38'sd0);
            r_a2_neg  <= r_d2_d2[37];
            r_a2_mag  <= r_d2_d2[37] ? neg_d2[35:0] : r_d2_d2[35:0];
            r_a2_nx   <= n_a2_nx;
            r_a2_ny   <= n_a2_ny;

            r_s2_mag     <= r_a2_mag;
            r_s2_nx      <= r_a2_nx;
            r_s2_ny      <= r_a2_ny;
            r_s2_sx.kill <= r_a2_kill;
            r_s2_sx.sg   <= r_a2_sx ^ r_a2_neg;
            // quotient of 2^17 or more puts the coordinate off the sensor
            r_s2_sx.sat  <= {11'b0, r_a2_nx} >= {r_a2_mag, 17'b0};
            r_s2_sy.kill <= r_a2_kill;
            r_s2_sy.sg   <= r_a2_sy ^ r_a2_neg;
            r_s2_sy.sat  <= {11'b0, r_a2_ny} >= {r_a2_mag, 17'b0};
        end
    end

    // ---------------- divider 3: |u| * f / |d2| ----------------
    logic        w_d3x_v;
    logic        w_d3y_v;
    logic [16:0] w_d3x_q;
    logic [16:0] w_d3y_q;
    t_side3      w_d3x_side;
    t_side3      w_d3y_side;

    rue_div_pipe #(.DW(36), .QW(17), .SW($bits(t_side3))) u_div_ox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_rem   ({11'b0, r_s2_nx[41:17]}),
        .i_den   (r_s2_mag),
        .i_bits  (r_s2_nx[16:0]),
        .i_side  (r_s2_sx),
        .o_valid (w_d3x_v),
        .o_quot  (w_d3x_q),
        .o_side  (w_d3x_side)
    );

    rue_div_pipe #(.DW(36), .QW(17), .SW($bits(t_side3))) u_div_oy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_rem   ({11'b0, r_s2_ny[41:17]}),
        .i_den   (r_s2_mag),
        .i_bits  (r_s2_ny[16:0]),
        .i_side  (r_s2_sy),
        .o_valid (w_d3y_v),
        .o_quot  (w_d3y_q),
        .o_side  (w_d3y_side)
    );

    // ---------------- add center back ----------------
    logic               r_o_v;
    logic               r_o_drop;
    logic signed [18:0] r_o_x;
    logic signed [18:0] r_o_y;
    logic [18:0]        qx_ext;
    logic [18:0]        qy_ext;

    assign qx_ext = {2'b00, w_d3x_q};
    assign qy_ext = {2'b00, w_d3y_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= w_d3x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_drop <= w_d3x_side.kill || w_d3x_side.sat || w_d3y_side.sat;
            r_o_x    <= $signed(w_d3x_side.sg ? -qx_ext : qx_ext)
                        + {{3{r_cx[15]}}, r_cx};
            r_o_y    <= $signed(w_d3y_side.sg ? -qy_ext : qy_ext)
                        + {{3{r_cy[15]}}, r_cy};
        end
    end

    // range check; zero focal length drops every word
    rue_pkg::t_result w_res;
    rue_pkg::t_result w_out;
    logic             ok;

    assign ok = !r_o_drop && (r_f != 18'd0)
                && !r_o_x[18] && (r_o_x[17:0] <= 18'(rue_pkg::OUT_LIM))
                && !r_o_y[18] && (r_o_y[17:0] <= 18'(rue_pkg::OUT_LIM));

    assign w_res.x        = ok ? r_o_x[14:0] : 15'd0;
    assign w_res.y        = ok ? r_o_y[14:0] : 15'd0;
    assign w_res.in_range = ok;

    rue_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_o_v),
        .i_word  (w_res),
        .o_full  (skid_full),
        .o_valid (o_valid),
        .o_word  (w_out),
        .i_stall (i_stall)
    );

    assign o_undist_x = w_out.x;
    assign o_undist_y = w_out.y;
    assign o_in_range = w_out.in_range;

    // x and y lanes of each divider pair carry the same word
    a_lane_d1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d1x_v == w_d1y_v)
        else $error("divider 1 lanes out of step");

    a_lane_d3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d3x_v == w_d3y_v)
        else $error("divider 3 lanes out of step");

    // while the input is stalled the pipeline's first and last stages hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_in_v) && $stable(r_o_v))
        else $error("pipeline moved during stall");

    // a word dropped for range reads as zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_undist_x == 15'd0 && o_undist_y == 15'd0))
        else $error("out-of-range word not zeroed");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the radial undistortion block.
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 91;

    typedef struct {
        logic [14:0] x;
        logic [14:0] y;
        logic        in_range;
    } t_coord;

    typedef struct {
        logic [6:0]  px;
        logic [6:0]  py;
        bit          known;
        logic [14:0] x;
        logic [14:0] y;
        logic        in_range;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [6:0]  pix_x;
    logic [6:0]  pix_y;
    logic        out_valid;
    logic        out_stall;
    logic [14:0] undist_x;
    logic [14:0] undist_y;
    logic        in_range;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [17:0] cfg_data;

    // Shadow copy of the configuration registers.
    longint lens_cx;
    longint lens_cy;
    longint lens_f;
    longint lens_k;

    t_coord coord_queue[$];
    int     n_mismatch;
    bit     stall_mode;

    radial_undistort_event DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_pix_x    (pix_x),
        .i_pix_y    (pix_y),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_undist_x (undist_x),
        .o_undist_y (undist_y),
        .o_in_range (in_range),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint sat(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Compute the undistorted coordinate from the shadow configuration.
    function automatic t_coord undistort(logic [6:0] px, logic [6:0] py);
        t_coord res;
        longint dx, dy, ux, uy, r2, d1, rc, d2, ox, oy, lim;
        res = '{default: '0};
        lim = longint'(rue_pkg::COORD_MAX) << rue_pkg::FRAC_BITS;
        if (lens_f == 0) return res;
        dx = (longint'(px) << rue_pkg::FRAC_BITS) - lens_cx;
        dy = (longint'(py) << rue_pkg::FRAC_BITS) - lens_cy;
        ux = sat((dx * 65536) / lens_f, 64'd16777215);
        uy = sat((dy * 65536) / lens_f, 64'd16777215);
        r2 = (ux * ux + uy * uy) >>> 16;
        d1 = 65536 + (lens_k * r2) / 16384;
        if (d1 == 0) return res;
        rc = sat((r2 * 65536) / d1, 64'd17179869183);
        d2 = 65536 + (lens_k * rc) / 16384;
        if (d2 == 0) return res;
        ox = (ux * lens_f) / d2 + lens_cx;
        oy = (uy * lens_f) / d2 + lens_cy;
        if (ox < 0 || ox > lim || oy < 0 || oy > lim) return res;
        res.x = ox[14:0];
        res.y = oy[14:0];
        res.in_range = 1'b1;
        return res;
    endfunction

    // Write one register at a falling edge and mirror it in the shadow copy.
    task automatic write_reg(logic [1:0] idx, logic [17:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            rue_pkg::CFG_CENTER_X:     lens_cx = longint'(signed'(val[15:0]));
            rue_pkg::CFG_CENTER_Y:     lens_cy = longint'(signed'(val[15:0]));
            rue_pkg::CFG_FOCAL_LENGTH: lens_f  = longint'(val);
            rue_pkg::CFG_RADIAL_COEFF: lens_k  = longint'(signed'(val[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_lens(int cx, int cy, int f, int k);
        write_reg(rue_pkg::CFG_CENTER_X, 18'(cx));
        write_reg(rue_pkg::CFG_CENTER_Y, 18'(cy));
        write_reg(rue_pkg::CFG_FOCAL_LENGTH, 18'(f));
        write_reg(rue_pkg::CFG_RADIAL_COEFF, 18'(k));
    endtask

    // Drive one word at a falling edge and hold it until accepted.
    task automatic send_word(logic [6:0] px, logic [6:0] py);
        @(negedge clk);
        in_valid <= 1'b1;
        pix_x    <= px;
        pix_y    <= py;
        do @(posedge clk); while (in_stall);
        coord_queue = {coord_queue, undistort(px, py)};
    endtask

    // Drive a burst of len words: drop valid only after the burst ends.
    task automatic send_burst(int len, bit rand_pix);
        repeat (len) begin
            if (rand_pix) send_word(7'($urandom), 7'($urandom));
            else send_word(7'($urandom_range(40, 90)), 7'($urandom_range(40, 90)));
        end
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
    endtask

    task automatic drain();
        while (coord_queue.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Check each accepted output word against the oldest expectation.
    always @(posedge clk) begin
        t_coord exp_c;
        if (rst_n && out_valid && !out_stall) begin
            if (coord_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected word x=%0d y=%0d in=%0b",
                             undist_x, undist_y, in_range);
            end else begin
                exp_c = coord_queue.pop_front();
                if (undist_x !== exp_c.x || undist_y !== exp_c.y ||
                    in_range !== exp_c.in_range) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: exp x=%0d y=%0d in=%0b got x=%0d y=%0d in=%0b",
                                 exp_c.x, exp_c.y, exp_c.in_range,
                                 undist_x, undist_y, in_range);
                end
            end
        end
    end

    // Receiver stall: alternate between free-running and heavy-stall stretches.
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
    end

    initial begin
        #20ms;
        $display("FAIL radial_undistort_event");
        $finish;
    end

    initial begin
        t_row rows [5];
        n_mismatch = 0;
        stall_mode = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pix_x = '0;
        pix_y = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        lens_cx = longint'(rue_pkg::RST_CENTER_X);
        lens_cy = longint'(rue_pkg::RST_CENTER_Y);
        lens_f  = longint'(rue_pkg::RST_FOCAL_LENGTH);
        lens_k  = longint'(signed'(rue_pkg::RST_RADIAL_COEFF));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings with k = 0 return the pixel, truncated toward the center.
        rows = '{
            '{7'd0,   7'd0,   1'b1, 15'd1,     15'd1,     1'b1},
            '{7'd127, 7'd127, 1'b1, 15'd32511, 15'd32511, 1'b1},
            '{7'd63,  7'd63,  1'b1, 15'd16128, 15'd16128, 1'b1},
            '{7'd127, 7'd0,   1'b1, 15'd32511, 15'd1,     1'b1},
            '{7'd85,  7'd42,  1'b0, 15'd0,     15'd0,     1'b0}
        };
        foreach (rows[i]) begin
            send_word(rows[i].px, rows[i].py);
            if (rows[i].known) begin
                coord_queue[coord_queue.size() - 1] =
                    '{rows[i].x, rows[i].y, rows[i].in_range};
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;
        drain();

        // Zero focal length: always out of range.
        set_lens(16128, 16128, 0, 0);
        send_burst(3, 1);
        drain();

        // Tiny focal length: normalized coordinate runs close to full scale.
        set_lens(-256, 32767, 256, 32767);
        send_burst(6, 1);
        drain();

        // Coefficient -1.0 with f = 256 px: zero first factor at r2 = 1.
        set_lens(0, 0, 65536, -16384);
        send_word(7'd127, 7'd0);
        send_word(7'd0, 7'd127);
        send_word(7'd90, 7'd90);
        @(negedge clk);
        in_valid <= 1'b0;
        drain();

        // Extreme negative coefficient, wide focal length.
        set_lens(16128, 16128, 262143, -32768);
        send_burst(6, 1);
        drain();

        // Random phases, each with its own lens settings.
        repeat (10) begin
            case ($urandom_range(0, 3))
                0: set_lens($urandom_range(0, 32767), $urandom_range(0, 32767),
                            $urandom_range(256, 262143), int'(16'($urandom)));
                1: set_lens($urandom_range(12000, 20000), $urandom_range(12000, 20000),
                            $urandom_range(20000, 80000), $urandom_range(0, 2000) - 1000);
                2: set_lens(-256 + $urandom_range(0, 512), 32767 - $urandom_range(0, 512),
                            $urandom_range(256, 4000), int'(16'($urandom)));
                default: set_lens(16128, 16128, 51200, $urandom_range(0, 8000) - 4000);
            endcase
            repeat (12) send_burst($urandom_range(1, 14), $urandom_range(0, 3) != 0);
            drain();
        end

        if (n_mismatch == 0) begin
            $display("PASS radial_undistort_event");
        end else begin
            $display("FAIL radial_undistort_event");
        end
        $finish;
    end

endmodule
